// ===== rtl/sosmc_pkg.sv =====
// Shared types, constants and codes for the sorted offset set.
package sosmc_pkg;
   localparam int CAPACITY     = 1024;
   localparam int OFFSET_WIDTH = 32;
   localparam int ADDR_WIDTH   = $clog2(CAPACITY);
   localparam int COUNT_WIDTH  = $clog2(CAPACITY + 1);

   localparam logic [2:0] OP_INSERT = 3'd0;
   localparam logic [2:0] OP_REWIND = 3'd1;
   localparam logic [2:0] OP_FIND   = 3'd2;
   localparam logic [2:0] OP_RESET  = 3'd3;
   localparam logic [2:0] OP_ABORT  = 3'd4;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_DUP     = 2'd1;
   localparam logic [1:0] ST_DUP_ERR = 2'd2;
   localparam logic [1:0] ST_FULL    = 2'd3;

   localparam logic [1:0] CSR_FORBID_DUP = 2'd0;

   typedef struct packed {
      logic [2:0]  op;
      logic [31:0] offset;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [1:0]  status;
      logic [10:0] stored_count;
      logic        count_valid;
      logic [10:0] skipped;
      logic        dup_error;
   } rsp_type;

   // commands from controller to datapath
   typedef struct packed {
      logic load;        // latch request, reset scan, shift and skip
      logic rd_scan;     // issue read at scan index
      logic rd_cursor;   // issue read at cursor
      logic scan_step;   // advance scan index
      logic shift_step;  // move one entry up
      logic write_new;   // write new offset at scan index
      logic cur_step;    // advance cursor, count skip
      logic cur_match;   // advance cursor, no skip
      logic set_status;
      logic [1:0] status;
      logic set_found;
      logic op_rewind;
      logic op_reset;
      logic op_abort;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic [2:0] op;
      logic scan_end;    // scan index reached count
      logic rd_lt;       // read data below offset
      logic rd_eq;
      logic cur_end;
      logic full;
      logic shift_done;
      logic all_found;
      logic forbid;
   } sts_type;
endpackage

// ===== rtl/sorted_offset_set_with_match_cursor_unit.sv =====
// Top level: sorted offset set with match cursor, APB register and handshakes.
// Usage: each req_ transaction carries an op (insert, rewind, find, reset,
// abort) and an offset; each yields exactly one rsp_ transaction holding
// found, status, stored_count, count_valid, skipped and dup_error.
// Sequencing: one item at a time. Insert scans the table entry by entry
// through the single memory read port, then shifts the upper entries
// one per cycle. Find walks from the cursor over the entries it passes.
// Offsets are matched with one compare per memory read; the table has
// one read port and one write port.
// Reset clears count, cursor and flags at once; table contents stay
// undefined and are never read beyond the count, so no clearing pass.
// A stalled receiver holds the result register; the next request is taken
// the cycle the waiting result is taken. The register forbid_duplicates
// sits at address 0; the user must write it only while idle (unchecked).
module sorted_offset_set_with_match_cursor_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  sosmc_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output sosmc_pkg::rsp_type rsp_data,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [1:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);
   import sosmc_pkg::*;

   cmd_type cmd;
   sts_type sts;
   logic    forbid_ff;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == CSR_FORBID_DUP) ? {31'd0, forbid_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) forbid_ff <= 1'b0;
      else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == CSR_FORBID_DUP)
         forbid_ff <= csr_pwdata[0];
   end

   sosmc_controller u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready, .sts, .cmd
   );

   sosmc_datapath u_dp (
      .clock, .reset, .req(req_data), .cmd, .forbid(forbid_ff), .sts, .rsp_data
   );

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !(rsp_valid && !rsp_ready))
      else $error("request taken while result stalled");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.stored_count <= 11'(CAPACITY))
      else $error("count above capacity");
endmodule

// ===== rtl/sosmc_datapath.sv =====
// Datapath: offset table memory, count, cursor, flags and result register.
module sosmc_datapath (
   input  logic              clock,
   input  logic              reset,
   input  sosmc_pkg::req_type req,
   input  sosmc_pkg::cmd_type cmd,
   input  logic              forbid,
   output sosmc_pkg::sts_type sts,
   output sosmc_pkg::rsp_type rsp_data
);
   import sosmc_pkg::*;

   logic [OFFSET_WIDTH-1:0] mem [CAPACITY];
   logic [OFFSET_WIDTH-1:0] rd_ff;
   logic [OFFSET_WIDTH-1:0] ofs_ff;
   logic [2:0]              op_ff;
   logic [COUNT_WIDTH-1:0]  count_ff, count_in;
   logic [COUNT_WIDTH-1:0]  cursor_ff, cursor_in;
   logic [COUNT_WIDTH-1:0]  scan_ff, scan_in;
   logic [COUNT_WIDTH-1:0]  shift_ff, shift_in;
   logic [COUNT_WIDTH-1:0]  skip_ff, skip_in;
   logic                    afm_ff, afm_in, ok_ff, ok_in, dup_ff, dup_in;
   logic                    found_ff, found_in;
   logic [1:0]              status_ff, status_in;
   rsp_type                 rsp_ff;
   logic [COUNT_WIDTH-1:0]  rd_addr;
   logic                    rd_en;
   logic                    wr_en;
   logic [COUNT_WIDTH-1:0]  wr_addr;
   logic [OFFSET_WIDTH-1:0] wr_data;

   // shift reads two below the slot it writes; the priming step above the
   // count only starts the read and writes nothing
   always_comb begin
      rd_en   = cmd.rd_scan | cmd.rd_cursor | cmd.shift_step;
      rd_addr = cmd.rd_cursor ? cursor_ff :
                cmd.shift_step ? shift_ff - COUNT_WIDTH'(2) : scan_ff;
      wr_en   = cmd.write_new | (cmd.shift_step && (shift_ff <= count_ff));
      wr_addr = cmd.write_new ? scan_ff : shift_ff;
      wr_data = cmd.write_new ? ofs_ff : rd_ff;
   end

   always_ff @(posedge clock) begin
      if (rd_en) rd_ff <= mem[rd_addr[ADDR_WIDTH-1:0]];
      if (wr_en) mem[wr_addr[ADDR_WIDTH-1:0]] <= wr_data;
      if (cmd.load) begin
         ofs_ff <= req.offset;
         op_ff  <= req.op;
      end
   end

   always_comb begin
      count_in  = count_ff;
      cursor_in = cursor_ff;
      scan_in   = scan_ff;
      shift_in  = shift_ff;
      skip_in   = skip_ff;
      afm_in    = afm_ff;
      ok_in     = ok_ff;
      dup_in    = dup_ff;
      found_in  = found_ff;
      status_in = status_ff;
      if (cmd.load) begin
         scan_in   = '0;
         shift_in  = count_ff + COUNT_WIDTH'(1);
         skip_in   = '0;
         found_in  = 1'b0;
         status_in = ST_OK;
      end
      if (cmd.scan_step) scan_in = scan_ff + COUNT_WIDTH'(1);
      if (cmd.shift_step) shift_in = shift_ff - COUNT_WIDTH'(1);
      if (cmd.write_new) count_in = count_ff + COUNT_WIDTH'(1);
      if (cmd.cur_step) begin
         cursor_in = cursor_ff + COUNT_WIDTH'(1);
         skip_in   = skip_ff + COUNT_WIDTH'(1);
      end
      if (cmd.cur_match) cursor_in = cursor_ff + COUNT_WIDTH'(1);
      if (cmd.set_found) found_in = 1'b1;
      if (cmd.set_status) begin
         status_in = cmd.status;
         if (cmd.status == ST_DUP_ERR) dup_in = 1'b1;
      end
      if (cmd.op_rewind) begin
         cursor_in = '0;
         afm_in    = (count_ff == '0) && ok_ff;
      end
      if (cmd.op_reset) begin
         count_in = '0; cursor_in = '0; ok_in = 1'b1; dup_in = 1'b0; afm_in = 1'b1;
      end
      if (cmd.op_abort) begin
         count_in = '0; cursor_in = '0; ok_in = 1'b0; afm_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0; cursor_ff <= '0; afm_ff <= 1'b0; ok_ff <= 1'b1; dup_ff <= 1'b0;
      end else begin
         count_ff <= count_in; cursor_ff <= cursor_in; afm_ff <= afm_in;
         ok_ff <= ok_in; dup_ff <= dup_in;
      end
      scan_ff   <= scan_in;
      shift_ff  <= shift_in;
      skip_ff   <= skip_in;
      found_ff  <= found_in;
      status_ff <= status_in;
      if (cmd.emit) begin
         rsp_ff.found        <= found_ff;
         rsp_ff.status       <= status_ff;
         rsp_ff.stored_count <= 11'(count_ff);
         rsp_ff.count_valid  <= ok_ff;
         rsp_ff.skipped      <= 11'(skip_ff);
         rsp_ff.dup_error    <= dup_ff;
      end
   end

   always_comb begin
      sts.op         = op_ff;
      sts.scan_end   = scan_ff >= count_ff;
      sts.rd_lt      = rd_ff < ofs_ff;
      sts.rd_eq      = rd_ff == ofs_ff;
      sts.cur_end    = cursor_ff >= count_ff;
      sts.full       = count_ff >= COUNT_WIDTH'(CAPACITY);
      sts.shift_done = shift_ff == scan_ff;
      sts.all_found  = afm_ff;
      sts.forbid     = forbid;
      rsp_data       = rsp_ff;
   end
endmodule

// ===== rtl/sosmc_controller.sv =====
// Controller: sequences insert scans, shifts, find walks and rewind, reset and abort.
module sosmc_controller (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  sosmc_pkg::sts_type sts,
   output sosmc_pkg::cmd_type cmd
);
   import sosmc_pkg::*;

   typedef enum logic [8:0] {
      S_IDLE  = 9'b0_0000_0001,
      S_DISP  = 9'b0_0000_0010,
      S_SCAN  = 9'b0_0000_0100,
      S_SHIFT = 9'b0_0000_1000,
      S_FIND  = 9'b0_0001_0000,
      S_WALK  = 9'b0_0010_0000,
      S_EMIT  = 9'b0_0100_0000,
      S_SETL  = 9'b0_1000_0000,
      S_SKIP  = 9'b1_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      vld_ff, vld_in;

   assign req_ready = (state_ff == S_IDLE) && (!vld_ff || rsp_ready);
   assign rsp_valid = vld_ff;

   always_comb begin
      state_in = state_ff;
      vld_in   = vld_ff && !rsp_ready;
      cmd      = '0;
      case (state_ff)
         S_IDLE: if (req_valid && req_ready) begin
            cmd.load = 1'b1;
            state_in = S_DISP;
         end
         S_DISP: begin
            case (sts.op)
               OP_INSERT: begin
                  if (sts.scan_end) begin
                     if (sts.full) begin
                        cmd.set_status = 1'b1; cmd.status = ST_FULL; state_in = S_EMIT;
                     end else begin
                        cmd.write_new = 1'b1; state_in = S_SETL;
                     end
                  end else begin
                     cmd.rd_scan = 1'b1; state_in = S_SCAN;
                  end
               end
               OP_REWIND: begin cmd.op_rewind = 1'b1; state_in = S_SETL; end
               OP_FIND: begin
                  if (sts.all_found) begin
                     cmd.set_found = 1'b1; state_in = S_EMIT;
                  end else if (sts.cur_end) state_in = S_EMIT;
                  else begin
                     cmd.rd_cursor = 1'b1; state_in = S_FIND;
                  end
               end
               OP_RESET: begin cmd.op_reset = 1'b1; state_in = S_SETL; end
               OP_ABORT: begin cmd.op_abort = 1'b1; state_in = S_SETL; end
               default: state_in = S_EMIT;
            endcase
         end
         S_SCAN: begin
            if (sts.rd_lt) begin
               cmd.scan_step = 1'b1; state_in = S_DISP;
            end else if (sts.rd_eq) begin
               cmd.set_status = 1'b1;
               cmd.status = sts.forbid ? ST_DUP_ERR : ST_DUP;
               state_in = S_SETL;
            end else if (sts.full) begin
               cmd.set_status = 1'b1; cmd.status = ST_FULL; state_in = S_EMIT;
            end else begin
               cmd.shift_step = 1'b1; state_in = S_SHIFT;
            end
         end
         // each step writes slot shift from the last read, reads shift-2
         S_SHIFT: begin
            if (sts.shift_done) begin
               cmd.write_new = 1'b1; state_in = S_SETL;
            end else cmd.shift_step = 1'b1;
         end
         // only the entry at the cursor may match
         S_FIND: begin
            if (sts.rd_eq) begin
               cmd.cur_match = 1'b1; cmd.set_found = 1'b1; state_in = S_SETL;
            end else if (sts.rd_lt) begin
               cmd.cur_step = 1'b1; state_in = S_WALK;
            end else state_in = S_EMIT;
         end
         S_WALK: begin
            if (sts.cur_end) state_in = S_EMIT;
            else begin
               cmd.rd_cursor = 1'b1; state_in = S_SKIP;
            end
         end
         // skip entries below the offset, stop on the first that is not
         S_SKIP: begin
            if (sts.rd_lt) begin
               cmd.cur_step = 1'b1; state_in = S_WALK;
            end else state_in = S_EMIT;
         end
         S_SETL: state_in = S_EMIT;
         S_EMIT: begin
            cmd.emit = 1'b1; vld_in = 1'b1; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in; vld_ff <= vld_in;
      end
   end
endmodule

// ===== tb/tb_sorted_offset_set_with_match_cursor_unit.sv =====
// Testbench for the sorted offset set with match cursor: scoreboarded random and directed runs.
`timescale 1ns / 1ps
module tb_sorted_offset_set_with_match_cursor_unit;
   import sosmc_pkg::*;

   localparam int STALL_LIMIT = 20000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [1:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   sorted_offset_set_with_match_cursor_unit dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // shadow of the set
   logic [31:0] shadow_tab [CAPACITY];
   int unsigned shadow_count = 0;
   int unsigned shadow_cursor = 0;
   bit          shadow_all_found = 1'b0;
   bit          shadow_count_ok = 1'b1;
   bit          shadow_sticky = 1'b0;
   bit          shadow_forbid = 1'b0;

   rsp_type     pending_rsp [$];
   int          errors = 0;
   int          send_idle_pct = 11;
   int          recv_idle_pct = 48;
   int          quiet_cycles = 0;

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   function automatic rsp_type apply_op(input req_type r);
      rsp_type     o;
      int unsigned pos;
      o = '0;
      case (r.op)
         OP_INSERT: begin
            pos = 0;
            while (pos < shadow_count && shadow_tab[pos] < r.offset) pos++;
            if (pos < shadow_count && shadow_tab[pos] == r.offset) begin
               if (shadow_forbid) begin
                  shadow_sticky = 1'b1;
                  o.status = ST_DUP_ERR;
               end else begin
                  o.status = ST_DUP;
               end
            end else if (shadow_count >= CAPACITY) begin
               o.status = ST_FULL;
            end else begin
               for (int i = shadow_count; i > pos; i--) shadow_tab[i] = shadow_tab[i-1];
               shadow_tab[pos] = r.offset;
               shadow_count++;
               o.status = ST_OK;
            end
         end
         OP_REWIND: begin
            shadow_cursor = 0;
            shadow_all_found = (shadow_count == 0) && shadow_count_ok;
         end
         OP_FIND: begin
            if (shadow_all_found) begin
               o.found = 1'b1;
            end else if (shadow_cursor < shadow_count) begin
               if (shadow_tab[shadow_cursor] == r.offset) begin
                  shadow_cursor++;
                  o.found = 1'b1;
               end else begin
                  while (shadow_cursor < shadow_count && r.offset > shadow_tab[shadow_cursor]) begin
                     shadow_cursor++;
                     o.skipped++;
                  end
               end
            end
         end
         OP_RESET: begin
            shadow_count = 0;
            shadow_cursor = 0;
            shadow_count_ok = 1'b1;
            shadow_sticky = 1'b0;
            shadow_all_found = 1'b1;
         end
         OP_ABORT: begin
            shadow_count = 0;
            shadow_cursor = 0;
            shadow_count_ok = 1'b0;
            shadow_all_found = 1'b0;
         end
         default: ;
      endcase
      o.stored_count = shadow_count[10:0];
      o.count_valid  = shadow_count_ok;
      o.dup_error    = shadow_sticky;
      return o;
   endfunction

   // check results first, then record the transaction taken at the same edge
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_rsp.size() == 0) begin
               $display("unexpected result transaction at %0t", $realtime);
               errors++;
            end else begin
               want = pending_rsp.pop_front();
               if (rsp_data.found !== want.found) report("found", rsp_data.found, want.found);
               if (rsp_data.status !== want.status) report("status", rsp_data.status, want.status);
               if (rsp_data.stored_count !== want.stored_count)
                  report("stored_count", rsp_data.stored_count, want.stored_count);
               if (rsp_data.count_valid !== want.count_valid)
                  report("count_valid", rsp_data.count_valid, want.count_valid);
               if (rsp_data.skipped !== want.skipped)
                  report("skipped", rsp_data.skipped, want.skipped);
               if (rsp_data.dup_error !== want.dup_error)
                  report("dup_error", rsp_data.dup_error, want.dup_error);
            end
         end
         if (req_valid && req_ready) pending_rsp.push_back(apply_op(req_data));
      end
   end

   always @(negedge clock) rsp_ready <= ($urandom_range(99) >= recv_idle_pct);

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > STALL_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic send_item(input logic [2:0] op, input logic [31:0] offset);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_data.op     <= op;
      req_data.offset <= offset;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic csr_write(input logic [31:0] value);
      wait_drained();
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_FORBID_DUP;
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      shadow_forbid = value[0];
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic test_directed();
      send_item(OP_FIND, 32'd3);            // empty valid set after reset: not in all-found yet
      send_item(OP_REWIND, 32'd0);
      send_item(OP_FIND, 32'd77);           // all-found
      send_item(OP_INSERT, 32'd0);
      send_item(OP_INSERT, 32'hFFFF_FFFF);
      send_item(OP_INSERT, 32'd5);
      send_item(OP_INSERT, 32'd5);          // duplicate ignored
      send_item(OP_FIND, 32'd9);            // all-found still holds until rewind
      send_item(OP_REWIND, 32'd0);
      send_item(OP_FIND, 32'd0);
      send_item(OP_FIND, 32'd4);
      send_item(OP_INSERT, 32'd2);          // insert after rewind
      send_item(OP_FIND, 32'hFFFF_FFFF);
      send_item(OP_FIND, 32'hFFFF_FFFF);    // matches the last entry at the cursor
      send_item(OP_ABORT, 32'hA5A5_5A5A);
      send_item(OP_INSERT, 32'd7);          // count stays invalid
      send_item(OP_REWIND, 32'd0);
      send_item(OP_FIND, 32'd7);
      send_item(3'd5, 32'h1234_5678);
      send_item(3'd6, 32'hFFFF_FFFF);
      send_item(3'd7, 32'd0);
      send_item(OP_RESET, 32'd0);
      csr_write(32'd1);
      send_item(OP_INSERT, 32'd9);
      send_item(OP_INSERT, 32'd9);          // duplicate error, sticky
      send_item(OP_FIND, 32'd9);
      send_item(OP_RESET, 32'd0);           // clears the sticky flag
      csr_write(32'd0);
   endtask

   task automatic test_full_table();
      send_item(OP_RESET, 32'd0);
      // descending offsets keep each insert at position zero
      for (int i = 0; i < CAPACITY; i++) send_item(OP_INSERT, 32'hFFFF_0000 - 32'(i) * 3);
      send_item(OP_INSERT, 32'd1);          // table full
      send_item(OP_INSERT, 32'hFFFF_0000);  // duplicate in a full table
      send_item(OP_REWIND, 32'd0);
      send_item(OP_FIND, 32'hFFFF_0000 - 32'(CAPACITY - 1) * 3);
      send_item(OP_FIND, 32'hFFFF_0000 - 32'(CAPACITY - 10) * 3 + 1);
      send_item(OP_FIND, 32'hFFFF_FFFF);
      send_item(OP_RESET, 32'd0);
   endtask

   function automatic logic [31:0] pick_offset(input bit narrow);
      return narrow ? 32'($urandom_range(0, 40)) : $urandom;
   endfunction

   task automatic test_random(input int target);
      int sent;
      int k;
      bit narrow;
      logic [31:0] probe;
      sent = 0;
      while (sent < target) begin
         if ($urandom_range(99) < 85) begin
            narrow = $urandom_range(1);
            if ($urandom_range(9) == 0) send_item(OP_ABORT, $urandom);
            else send_item(OP_RESET, $urandom);
            k = $urandom_range(0, 12);
            for (int i = 0; i < k; i++) send_item(OP_INSERT, pick_offset(narrow));
            if (shadow_count > 0 && $urandom_range(2) == 0)
               send_item(OP_INSERT, shadow_tab[$urandom_range(shadow_count - 1)]);
            send_item(OP_REWIND, $urandom);
            sent += k + 3;
            for (int i = 0; i < shadow_count; i++) begin
               probe = shadow_tab[i];
               case ($urandom_range(3))
                  0: begin send_item(OP_FIND, probe); sent++; end
                  1: if (probe != 0) begin send_item(OP_FIND, probe - 1); sent++; end
                  2: ;
                  default: if (probe != 32'hFFFF_FFFF) begin
                     send_item(OP_FIND, probe + 1);
                     sent++;
                  end
               endcase
               if ($urandom_range(19) == 0) begin
                  send_item(OP_INSERT, pick_offset(narrow));
                  sent++;
               end
            end
            if ($urandom_range(1)) begin
               send_item(OP_FIND, pick_offset(narrow));
               sent++;
            end
         end else begin
            for (int i = 0; i < 4; i++) send_item(3'($urandom_range(7)), $urandom);
            sent += 4;
         end
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      csr_write(32'd1);
      test_random(150);
      csr_write(32'd0);
      test_random(150);
      send_idle_pct = 48;
      recv_idle_pct = 11;
      csr_write(32'd1);
      test_random(150);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      csr_write(32'd0);
      test_random(150);
      test_full_table();
      wait_drained();
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule
